// ----- rtl/cdc_pkg.sv -----
package cdc_pkg;

  localparam int unsigned FIRST_YEAR    = 1970;
  localparam int unsigned LAST_YEAR_DEF = 2038;

  // Four consecutive years from 1970 hold exactly one leap year (the third).
  localparam int unsigned CYCLE_DAYS  = 1461;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned RECIP_MUL   = (2 ** RECIP_SHIFT + CYCLE_DAYS - 1) / CYCLE_DAYS;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_DATE  = 2'd1,
    STATUS_BAD_COUNT = 2'd2
  } status_e;

  typedef struct packed {
    logic        opcode;
    logic [13:0] year_in;
    logic [6:0]  month_in;
    logic [6:0]  day_in;
    logic [14:0] count_in;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] count_out;
    logic [10:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
  } out_t;

  // Length of month m; zero for a month number that means nothing.
  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days of the year that come before the first of month m.
  function automatic logic [8:0] cum_start(logic [3:0] m, logic leap);
    logic [8:0] base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ----- rtl/cdc_month_split.sv -----
module cdc_month_split (
  input  logic [8:0] doy_i,
  input  logic       leap_i,
  output logic [3:0] month_o,
  output logic [4:0] day_o
);

  logic [3:0] month;
  logic [8:0] offset;

  // The month is the last one whose first day is not after the day of year.
  always_comb begin
    month = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (doy_i >= cdc_pkg::cum_start(4'(k), leap_i)) begin
        month = 4'(k);
      end
    end
    offset = doy_i - cdc_pkg::cum_start(month, leap_i);
  end

  assign month_o = month;
  assign day_o   = 5'(offset + 9'd1);

endmodule

// ----- rtl/civil_date_day_count_converter_unit.sv -----
// Converts between a civil date and the count of days since 1970-01-01, in either direction
// as the item's opcode selects, for years 1970 through LAST_YEAR. The block is a four-stage
// pipeline: it takes one item every cycle while in_ready_o is high, and each result passes
// through the stage 1, stage 2, stage 3 and output registers. Each stage holds its item
// until the next one can take it, so a stall at the output fills the empty stages before
// in_ready_o drops. Encode flags a bad date with status 1, decode flags a count past the
// last day of LAST_YEAR with status 2; all other result fields are zero then.
module civil_date_day_count_converter_unit #(
  parameter int unsigned LAST_YEAR = cdc_pkg::LAST_YEAR_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cdc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cdc_pkg::out_t out_data_o
);

  localparam int unsigned SPAN_YEARS = LAST_YEAR + 1 - cdc_pkg::FIRST_YEAR;
  localparam int unsigned LIMIT_DAYS = SPAN_YEARS * 365 + (SPAN_YEARS + 1) / 4;

  logic rdy1, rdy2, rdy3, rdy4;
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;

  // Stage 1: checks and the reciprocal product for the four-year split.
  cdc_pkg::status_e s1_status_d, s1_status_q;
  logic             s1_op_q;
  logic             s1_leap_d, s1_leap_q;
  logic [7:0]       s1_yo_q;
  logic [3:0]       s1_month_q;
  logic [4:0]       s1_day_q;
  logic [14:0]      s1_cnt_q;
  logic [30:0]      s1_prod_d, s1_prod_q;
  logic [4:0]       s1_mdays;
  logic             enc_ok, dec_ok;

  // Stage 2
  cdc_pkg::status_e s2_status_q;
  logic             s2_op_q;
  logic [16:0]      s2_base_d, s2_base_q;
  logic [5:0]       s2_leaps_d, s2_leaps_q;
  logic [8:0]       s2_cumday_d, s2_cumday_q;
  logic [4:0]       s2_quad_d, s2_quad_q;
  logic [10:0]      s2_rem_d, s2_rem_q;

  // Stage 3
  cdc_pkg::status_e s3_status_q;
  logic             s3_op_q;
  logic [14:0]      s3_count_d, s3_count_q;
  logic [10:0]      s3_year_d, s3_year_q;
  logic [8:0]       s3_doy_d, s3_doy_q;
  logic             s3_leap_d, s3_leap_q;
  logic [1:0]       s3_yidx;
  logic [10:0]      s3_ystart;

  // Output stage
  cdc_pkg::out_t out_d, out_q;
  logic [3:0]    dec_month;
  logic [4:0]    dec_day;

  assign rdy4       = !out_valid_q || out_ready_i;
  assign rdy3       = !s3_valid_q || rdy4;
  assign rdy2       = !s2_valid_q || rdy3;
  assign rdy1       = !s1_valid_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid_q <= in_valid_i;
      end
      if (rdy2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (rdy3) begin
        s3_valid_q <= s2_valid_q;
      end
      if (rdy4) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Within 1970..2099 every year divisible by four is a leap year.
  always_comb begin
    s1_leap_d = (in_data_i.year_in[1:0] == 2'b00);
    s1_mdays  = cdc_pkg::month_days(in_data_i.month_in[3:0], s1_leap_d);
    enc_ok    = (in_data_i.year_in >= 14'(cdc_pkg::FIRST_YEAR)) &&
                (in_data_i.year_in <= 14'(LAST_YEAR)) &&
                (in_data_i.month_in inside {[7'd1:7'd12]}) &&
                (in_data_i.day_in >= 7'd1) &&
                (in_data_i.day_in <= {2'b00, s1_mdays});
    dec_ok    = ({1'b0, in_data_i.count_in} < 16'(LIMIT_DAYS));
    if (in_data_i.opcode == cdc_pkg::OP_ENCODE) begin
      s1_status_d = enc_ok ? cdc_pkg::STATUS_OK : cdc_pkg::STATUS_BAD_DATE;
    end else begin
      s1_status_d = dec_ok ? cdc_pkg::STATUS_OK : cdc_pkg::STATUS_BAD_COUNT;
    end
    s1_prod_d = 31'(in_data_i.count_in) * 31'(cdc_pkg::RECIP_MUL);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_status_q <= s1_status_d;
      s1_op_q     <= in_data_i.opcode;
      s1_leap_q   <= s1_leap_d;
      s1_yo_q     <= 8'(in_data_i.year_in - 14'(cdc_pkg::FIRST_YEAR));
      s1_month_q  <= in_data_i.month_in[3:0];
      s1_day_q    <= in_data_i.day_in[4:0];
      s1_cnt_q    <= in_data_i.count_in;
      s1_prod_q   <= s1_prod_d;
    end
  end

  // Stage 2: year base and day of year for encode; four-year block and remainder for decode.
  always_comb begin
    s2_base_d   = 17'(s1_yo_q) * 17'd365;
    s2_leaps_d  = 6'((9'(s1_yo_q) + 9'd1) >> 2);
    s2_cumday_d = cdc_pkg::cum_start(s1_month_q, s1_leap_q) + 9'(s1_day_q) - 9'd1;
    s2_quad_d   = s1_prod_q[cdc_pkg::RECIP_SHIFT +: 5];
    s2_rem_d    = 11'(s1_cnt_q - 15'(15'(s2_quad_d) * 15'(cdc_pkg::CYCLE_DAYS)));
  end

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_status_q <= s1_status_q;
      s2_op_q     <= s1_op_q;
      s2_base_q   <= s2_base_d;
      s2_leaps_q  <= s2_leaps_d;
      s2_cumday_q <= s2_cumday_d;
      s2_quad_q   <= s2_quad_d;
      s2_rem_q    <= s2_rem_d;
    end
  end

  // Stage 3: final count for encode; year and day of year for decode.
  always_comb begin
    if (s2_rem_q < 11'd365) begin
      s3_yidx   = 2'd0;
      s3_ystart = 11'd0;
    end else if (s2_rem_q < 11'd730) begin
      s3_yidx   = 2'd1;
      s3_ystart = 11'd365;
    end else if (s2_rem_q < 11'd1096) begin
      s3_yidx   = 2'd2;
      s3_ystart = 11'd730;
    end else begin
      s3_yidx   = 2'd3;
      s3_ystart = 11'd1096;
    end
    s3_count_d = 15'(s2_base_q + 17'(s2_leaps_q) + 17'(s2_cumday_q));
    s3_year_d  = 11'(cdc_pkg::FIRST_YEAR) + {4'b0000, s2_quad_q, s3_yidx};
    s3_doy_d   = 9'(s2_rem_q - s3_ystart);
    s3_leap_d  = (s3_yidx == 2'd2);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_status_q <= s2_status_q;
      s3_op_q     <= s2_op_q;
      s3_count_q  <= s3_count_d;
      s3_year_q   <= s3_year_d;
      s3_doy_q    <= s3_doy_d;
      s3_leap_q   <= s3_leap_d;
    end
  end

  cdc_month_split u_month_split (
    .doy_i   (s3_doy_q),
    .leap_i  (s3_leap_q),
    .month_o (dec_month),
    .day_o   (dec_day)
  );

  always_comb begin
    out_d        = '0;
    out_d.status = s3_status_q;
    if (s3_status_q == cdc_pkg::STATUS_OK) begin
      if (s3_op_q == cdc_pkg::OP_ENCODE) begin
        out_d.count_out = s3_count_q;
      end else begin
        out_d.year_out  = s3_year_q;
        out_d.month_out = dec_month;
        out_d.day_out   = dec_day;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A stalled stage keeps its item.
  a_stage3_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !rdy4 |=> s3_valid_q)
    else $error("stage 3 item lost during stall");

  a_doy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && (s3_op_q == cdc_pkg::OP_DECODE) && (s3_status_q == cdc_pkg::STATUS_OK)
    |-> (s3_doy_q < (s3_leap_q ? 9'd366 : 9'd365)))
    else $error("day of year out of range");

  a_decoded_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == 2'(cdc_pkg::STATUS_OK)) &&
    (out_data_o.month_out != 4'd0)
    |-> (out_data_o.count_out == 15'd0) && (out_data_o.day_out != 5'd0) &&
        (out_data_o.month_out <= 4'd12) &&
        (out_data_o.year_out >= 11'(cdc_pkg::FIRST_YEAR)) &&
        (out_data_o.year_out <= 11'(LAST_YEAR)))
    else $error("decoded date out of range");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != 2'(cdc_pkg::STATUS_OK))
    |-> (out_data_o.count_out == 15'd0) && (out_data_o.year_out == 11'd0) &&
        (out_data_o.month_out == 4'd0) && (out_data_o.day_out == 5'd0))
    else $error("error result carries nonzero fields");

endmodule
